// ----- hdl/cascaded_position_velocity_pi_core_defines.svh -----
`ifndef CASCADED_POSITION_VELOCITY_PI_CORE_DEFINES_SVH
`define CASCADED_POSITION_VELOCITY_PI_CORE_DEFINES_SVH

`ifndef SYNTH
`define CPVP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cpvp assertion failed");
`define CPVP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cpvp assertion failed");
`else
`define CPVP_ASSERT(lbl, clk, rst_n, prop)
`define CPVP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hdl/cpvp_pkg.sv -----
package cpvp_pkg;

    localparam int CPVP_AXES = 2;

    localparam int DATA_W  = 32;
    localparam int LIM_W   = 31;
    localparam int ERR_W   = DATA_W + 1;
    localparam int PROD_W  = 2 * ERR_W;
    localparam int FRAC_W  = 16;
    localparam int SHR_W   = PROD_W - FRAC_W;
    localparam int ACC_W   = SHR_W + 1;
    localparam int CFG_AW  = 3;
    localparam int STEP_W  = 4;
    localparam int UC_LAST = 9;

    typedef enum logic [CFG_AW-1:0] {
        CFG_COEF_A        = 3'd0,
        CFG_COEF_B        = 3'd1,
        CFG_COEF_C        = 3'd2,
        CFG_COEF_D        = 3'd3,
        CFG_POS_GAIN      = 3'd4,
        CFG_SPEED_LIMIT   = 3'd5,
        CFG_CURRENT_LIMIT = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_a;
        logic signed [DATA_W-1:0] coef_b;
        logic signed [DATA_W-1:0] coef_c;
        logic signed [DATA_W-1:0] coef_d;
        logic signed [DATA_W-1:0] pos_gain;
        logic [LIM_W-1:0]         speed_limit;
        logic [LIM_W-1:0]         current_limit;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        coef_a:        32'sd65536,
        coef_b:        '0,
        coef_c:        '0,
        coef_d:        '0,
        pos_gain:      '0,
        speed_limit:   '1,
        current_limit: '1
    };

    typedef enum logic [2:0] {
        MA_COEF_A,
        MA_COEF_B,
        MA_COEF_C,
        MA_COEF_D,
        MA_POS_GAIN
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_X,
        MB_ERR,
        MB_PERR
    } t_mul_b;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD_CMD,
        ACT_VREF_PROD,
        ACT_CLAMP_V,
        ACT_ERR,
        ACT_CLAMP_I,
        ACT_STORE
    } t_act;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_IF_VEL,
        JMP_END
    } t_jmp;

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } t_seq_state;

    typedef struct packed {
        t_mul_a             mul_a;
        t_mul_b             mul_b;
        logic               mul_en;
        t_acc_op            acc_op;
        t_act               act;
        t_jmp               jmp;
        logic [STEP_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic vel_mode;
        logic out_full;
    } t_seq_stat;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] current;
        logic              speed_hit;
        logic              current_hit;
    } t_result;

    localparam t_uword UW_NOP = '{
        mul_a:  MA_COEF_A,
        mul_b:  MB_X,
        mul_en: 1'b0,
        acc_op: ACC_HOLD,
        act:    ACT_NONE,
        jmp:    JMP_NEXT,
        target: '0
    };

    // control program, one word per step
    function automatic t_uword cpvp_rom(input logic [STEP_W-1:0] step);
        t_uword uw;
        uw = UW_NOP;
        unique case (step)
            STEP_W'(0): begin
                uw.act    = ACT_LOAD_CMD;
                uw.jmp    = JMP_IF_VEL;
                uw.target = STEP_W'(3);
            end
            STEP_W'(1): begin
                uw.mul_a  = MA_POS_GAIN;
                uw.mul_b  = MB_PERR;
                uw.mul_en = 1'b1;
            end
            STEP_W'(2): begin
                uw.act = ACT_VREF_PROD;
            end
            STEP_W'(3): begin
                uw.act = ACT_CLAMP_V;
            end
            STEP_W'(4): begin
                uw.act    = ACT_ERR;
                uw.mul_a  = MA_COEF_C;
                uw.mul_b  = MB_X;
                uw.mul_en = 1'b1;
            end
            STEP_W'(5): begin
                uw.mul_a  = MA_COEF_D;
                uw.mul_b  = MB_ERR;
                uw.mul_en = 1'b1;
                uw.acc_op = ACC_LOAD;
            end
            STEP_W'(6): begin
                uw.mul_a  = MA_COEF_A;
                uw.mul_b  = MB_X;
                uw.mul_en = 1'b1;
                uw.acc_op = ACC_ADD;
            end
            STEP_W'(7): begin
                uw.mul_a  = MA_COEF_B;
                uw.mul_b  = MB_ERR;
                uw.mul_en = 1'b1;
                uw.acc_op = ACC_LOAD;
                uw.act    = ACT_CLAMP_I;
            end
            STEP_W'(8): begin
                uw.acc_op = ACC_ADD;
            end
            STEP_W'(UC_LAST): begin
                uw.act = ACT_STORE;
                uw.jmp = JMP_END;
            end
            default: begin
                uw = UW_NOP;
            end
        endcase
        return uw;
    endfunction

endpackage

// ----- hdl/cascaded_position_velocity_pi_core.sv -----
// cascaded position / velocity pi core, two axes sharing one coefficient set
// input words on s_*: tuser selects request type and axis, tdata carries the
// command and the measured position and velocity. a position request runs the
// proportional position loop first; a velocity request uses the command as is.
// result words on m_*: clamped current command in tdata, clamp flags in tuser.
// coefficients and limits are to be written through i_cfg_* by the user only
// while the core is idle; the block itself does not enforce this.
// s_tready rises in the same cycle as m_tvalid, so a new word is taken only
// after the last one is finished. the core uses a single shared 33x33
// multiplier: up to five products per word, stepped by the control program
// one step per cycle except while the final store step holds.
// a finished result waits in the output register; the next word is accepted
// and computed meanwhile, and only the final store step holds while m_tready
// is low and the output register is still full.
// reset (synchronous, active low) clears both axis states, restores the
// register defaults and empties the output register.
`include "cascaded_position_velocity_pi_core_defines.svh"

module cascaded_position_velocity_pi_core
    import cpvp_pkg::*;
#(
    parameter int AXES = CPVP_AXES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [95:0]       s_tdata,   // command, measured_position, measured_velocity
    input  logic [1:0]        s_tuser,   // req_type, axis
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // current_command
    output logic [1:0]        m_tuser,   // speed_clamped, current_clamped
    input  logic              i_cfg_wen,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_wdata
);

    t_cfg              r_cfg;
    logic              r_m_valid;
    logic [DATA_W-1:0] r_m_data;
    logic [1:0]        r_m_user;

    t_uword    uw;
    t_seq_stat stat;
    t_result   res;
    logic      idle;
    logic      vel_mode;
    logic      s_accept;

    assign s_tready = idle;
    assign s_accept = s_tvalid && idle;

    assign stat.vel_mode = vel_mode;
    assign stat.out_full = r_m_valid && !m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                CFG_COEF_A:        r_cfg.coef_a        <= i_cfg_wdata;
                CFG_COEF_B:        r_cfg.coef_b        <= i_cfg_wdata;
                CFG_COEF_C:        r_cfg.coef_c        <= i_cfg_wdata;
                CFG_COEF_D:        r_cfg.coef_d        <= i_cfg_wdata;
                CFG_POS_GAIN:      r_cfg.pos_gain      <= i_cfg_wdata;
                CFG_SPEED_LIMIT:   r_cfg.speed_limit   <= i_cfg_wdata[LIM_W-1:0];
                CFG_CURRENT_LIMIT: r_cfg.current_limit <= i_cfg_wdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cpvp_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept),
        .i_stat  (stat),
        .o_uw    (uw),
        .o_idle  (idle)
    );

    cpvp_dp #(
        .AXES (AXES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_uw                (uw),
        .i_cfg               (r_cfg),
        .i_load              (s_accept),
        .i_req_type          (s_tuser[0]),
        .i_axis              (s_tuser[1]),
        .i_command           (s_tdata[31:0]),
        .i_measured_position (s_tdata[63:32]),
        .i_measured_velocity (s_tdata[95:64]),
        .o_vel_mode          (vel_mode),
        .o_res               (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res.valid) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_m_data <= res.current;
            r_m_user <= {res.current_hit, res.speed_hit};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

    `CPVP_ASSERT(a_no_result_overrun, i_clk, i_rst_n, res.valid |-> !(r_m_valid && !m_tready))
    `CPVP_ASSERT(a_busy_after_accept, i_clk, i_rst_n, s_accept |=> !s_tready)
    `CPVP_ASSERT(a_result_held, i_clk, i_rst_n, (m_tvalid && !m_tready) |=> m_tvalid)

endmodule

// ----- hdl/cpvp_useq.sv -----
`include "cascaded_position_velocity_pi_core_defines.svh"

module cpvp_useq
    import cpvp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_seq_stat i_stat,
    output t_uword    o_uw,
    output logic      o_idle
);

    t_seq_state        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            uw_raw;
    logic              stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        uw_raw  = cpvp_rom(r_step);
        stall   = (uw_raw.jmp == JMP_END) && i_stat.out_full;
        n_state = r_state;
        n_step  = r_step;
        o_uw    = UW_NOP;
        unique case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    n_state = SQ_RUN;
                    n_step  = '0;
                end
            end
            SQ_RUN: begin
                o_uw = stall ? UW_NOP : uw_raw;
                unique case (uw_raw.jmp)
                    JMP_NEXT: begin
                        n_step = r_step + STEP_W'(1);
                    end
                    JMP_IF_VEL: begin
                        n_step = i_stat.vel_mode ? uw_raw.target : r_step + STEP_W'(1);
                    end
                    JMP_END: begin
                        if (!stall) begin
                            n_state = SQ_IDLE;
                            n_step  = '0;
                        end
                    end
                    default: begin
                        n_step = r_step + STEP_W'(1);
                    end
                endcase
            end
            default: begin
                n_state = SQ_IDLE;
                n_step  = '0;
            end
        endcase
    end

    assign o_idle = (r_state == SQ_IDLE);

    `CPVP_ASSERT(a_idle_step_zero, i_clk, i_rst_n, (r_state == SQ_IDLE) |-> (r_step == '0))
    `CPVP_ASSERT(a_step_in_program, i_clk, i_rst_n, r_step <= STEP_W'(UC_LAST))
    `CPVP_ASSERT(a_start_when_idle, i_clk, i_rst_n, i_start |-> (r_state == SQ_IDLE))

endmodule

// ----- hdl/cpvp_dp.sv -----
module cpvp_dp
    import cpvp_pkg::*;
#(
    parameter int AXES = CPVP_AXES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_uword                   i_uw,
    input  t_cfg                     i_cfg,
    input  logic                     i_load,
    input  logic                     i_req_type,
    input  logic                     i_axis,
    input  logic signed [DATA_W-1:0] i_command,
    input  logic signed [DATA_W-1:0] i_measured_position,
    input  logic signed [DATA_W-1:0] i_measured_velocity,
    output logic                     o_vel_mode,
    output t_result                  o_res
);

    localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'($signed(32'h7fff_ffff));
    localparam logic signed [ACC_W-1:0] S32_MIN = ACC_W'($signed(32'h8000_0000));

    function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v > S32_MAX) begin
            r = S32_MAX[DATA_W-1:0];
        end else if (v < S32_MIN) begin
            r = S32_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // {hit, value}
    function automatic logic [DATA_W:0] clamp_sym(input logic signed [ACC_W-1:0] v,
                                                   input logic [LIM_W-1:0] lim);
        logic signed [ACC_W-1:0] l;
        logic signed [ACC_W-1:0] nl;
        logic [DATA_W:0]         r;
        l  = $signed({{(ACC_W-LIM_W){1'b0}}, lim});
        nl = -l;
        if (v > l) begin
            r = {1'b1, l[DATA_W-1:0]};
        end else if (v < nl) begin
            r = {1'b1, nl[DATA_W-1:0]};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

    logic                     r_req, n_req;
    logic [AX_W-1:0]          r_axis, n_axis;
    logic signed [DATA_W-1:0] r_cmd, n_cmd;
    logic signed [DATA_W-1:0] r_pos, n_pos;
    logic signed [DATA_W-1:0] r_vel, n_vel;
    logic signed [DATA_W-1:0] r_perr, n_perr;
    logic signed [SHR_W-1:0]  r_vref, n_vref;
    logic signed [ERR_W-1:0]  r_err, n_err;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [DATA_W-1:0]        r_cur, n_cur;
    logic                     r_spd_hit, n_spd_hit;
    logic                     r_cur_hit, n_cur_hit;
    logic signed [DATA_W-1:0] r_state [AXES];

    logic signed [DATA_W-1:0] x;
    logic signed [ERR_W-1:0]  mul_a;
    logic signed [ERR_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [SHR_W-1:0]  p_shr;
    logic signed [ERR_W-1:0]  diff;
    logic [DATA_W:0]          clamp_v;
    logic [DATA_W:0]          clamp_i;

    assign x     = r_state[r_axis];
    assign p_shr = r_prod[PROD_W-1:FRAC_W];
    assign diff  = ERR_W'(r_cmd) - ERR_W'(r_pos);
    assign prod  = mul_a * mul_b;

    assign clamp_v = clamp_sym(ACC_W'(r_vref), i_cfg.speed_limit);
    assign clamp_i = clamp_sym(r_acc, i_cfg.current_limit);

    always_comb begin
        unique case (i_uw.mul_a)
            MA_COEF_A:   mul_a = ERR_W'(i_cfg.coef_a);
            MA_COEF_B:   mul_a = ERR_W'(i_cfg.coef_b);
            MA_COEF_C:   mul_a = ERR_W'(i_cfg.coef_c);
            MA_COEF_D:   mul_a = ERR_W'(i_cfg.coef_d);
            MA_POS_GAIN: mul_a = ERR_W'(i_cfg.pos_gain);
            default:     mul_a = '0;
        endcase
        unique case (i_uw.mul_b)
            MB_X:    mul_b = ERR_W'(x);
            MB_ERR:  mul_b = r_err;
            MB_PERR: mul_b = ERR_W'(r_perr);
            default: mul_b = '0;
        endcase
    end

    always_comb begin
        n_req     = r_req;
        n_axis    = r_axis;
        n_cmd     = r_cmd;
        n_pos     = r_pos;
        n_vel     = r_vel;
        n_perr    = r_perr;
        n_vref    = r_vref;
        n_err     = r_err;
        n_prod    = r_prod;
        n_acc     = r_acc;
        n_cur     = r_cur;
        n_spd_hit = r_spd_hit;
        n_cur_hit = r_cur_hit;

        if (i_load) begin
            n_req  = i_req_type;
            n_axis = (AXES > 1) ? AX_W'(i_axis) : '0;
            n_cmd  = i_command;
            n_pos  = i_measured_position;
            n_vel  = i_measured_velocity;
        end

        if (i_uw.mul_en) begin
            n_prod = prod;
        end

        case (i_uw.acc_op)
            ACC_LOAD: n_acc = ACC_W'(p_shr);
            ACC_ADD:  n_acc = r_acc + ACC_W'(p_shr);
            default:  n_acc = r_acc;
        endcase

        unique case (i_uw.act)
            ACT_LOAD_CMD: begin
                n_perr = sat32(ACC_W'(diff));
                n_vref = SHR_W'(r_cmd);
            end
            ACT_VREF_PROD: begin
                n_vref = p_shr;
            end
            ACT_CLAMP_V: begin
                n_spd_hit = clamp_v[DATA_W];
                n_vref    = SHR_W'($signed(clamp_v[DATA_W-1:0]));
            end
            ACT_ERR: begin
                n_err = ERR_W'($signed(r_vref[DATA_W-1:0])) - ERR_W'(r_vel);
            end
            ACT_CLAMP_I: begin
                n_cur_hit = clamp_i[DATA_W];
                n_cur     = clamp_i[DATA_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_axis    <= n_axis;
        r_cmd     <= n_cmd;
        r_pos     <= n_pos;
        r_vel     <= n_vel;
        r_perr    <= n_perr;
        r_vref    <= n_vref;
        r_err     <= n_err;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_cur     <= n_cur;
        r_spd_hit <= n_spd_hit;
        r_cur_hit <= n_cur_hit;
    end

    // per-axis loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_state[i] <= '0;
            end
        end else if (i_uw.act == ACT_STORE) begin
            r_state[r_axis] <= sat32(r_acc);
        end
    end

    assign o_vel_mode        = !r_req;
    assign o_res.valid       = (i_uw.act == ACT_STORE);
    assign o_res.current     = r_cur;
    assign o_res.speed_hit   = r_spd_hit;
    assign o_res.current_hit = r_cur_hit;

endmodule

// ----- verif/cascaded_position_velocity_pi_core_tb.sv -----
module cascaded_position_velocity_pi_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cpvp_pkg::*;

    localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd7;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] current;
        logic        speed_hit;
        logic        current_hit;
    } t_torque_cmd;

    typedef struct {
        bit                is_cfg;
        logic [CFG_AW-1:0] idx;
        logic [31:0]       val;
        bit                req;
        bit                ax;
        logic [31:0]       cmd;
        logic [31:0]       pos;
        logic [31:0]       vel;
        bit                typed;
        t_torque_cmd       word;
    } t_plan_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [95:0]       s_tdata = '0;   // command, measured_position, measured_velocity
    logic [1:0]        s_tuser = '0;   // req_type, axis
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;        // current_command
    logic [1:0]        m_tuser;        // speed_clamped, current_clamped
    logic              i_cfg_wen = 1'b0;
    logic [CFG_AW-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0] i_cfg_wdata = '0;

    t_cfg              gains;
    logic signed [31:0] axis_x [CPVP_AXES];
    t_torque_cmd       torque_q [$];
    t_plan_row         plan_q [$];
    int                bad_words = 0;

    cascaded_position_velocity_pi_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint sat_s32(longint v);
        if (v > S32_HI) return S32_HI;
        if (v < S32_LO) return S32_LO;
        return v;
    endfunction

    // exact product, floor shift back to q16.16
    function automatic longint q16_mul(logic signed [31:0] k, longint v);
        logic signed [65:0] wide_k;
        logic signed [65:0] wide_v;
        logic signed [65:0] prod;
        wide_k = k;
        wide_v = v;
        prod = wide_k * wide_v;
        return longint'(prod >>> 16);
    endfunction

    function automatic t_torque_cmd predict_current(bit req, bit ax, logic [31:0] cmd_w,
                                                    logic [31:0] pos_w, logic [31:0] vel_w);
        longint cmd;
        longint pos;
        longint vel;
        longint vref;
        longint err;
        longint cur;
        longint lim;
        t_torque_cmd r;
        cmd = longint'($signed(cmd_w));
        pos = longint'($signed(pos_w));
        vel = longint'($signed(vel_w));
        r = '0;
        if (req) begin
            vref = q16_mul(gains.pos_gain, sat_s32(cmd - pos));
        end else begin
            vref = cmd;
        end
        lim = longint'(gains.speed_limit);
        if (vref > lim) begin
            vref = lim;
            r.speed_hit = 1'b1;
        end else if (vref < -lim) begin
            vref = -lim;
            r.speed_hit = 1'b1;
        end
        // velocity error stays exact, no saturation
        err = vref - vel;
        cur = q16_mul(gains.coef_c, axis_x[ax]) + q16_mul(gains.coef_d, err);
        axis_x[ax] = 32'(sat_s32(q16_mul(gains.coef_a, axis_x[ax])
                                 + q16_mul(gains.coef_b, err)));
        lim = longint'(gains.current_limit);
        if (cur > lim) begin
            cur = lim;
            r.current_hit = 1'b1;
        end else if (cur < -lim) begin
            cur = -lim;
            r.current_hit = 1'b1;
        end
        r.current = cur[31:0];
        return r;
    endfunction

    function automatic void note_failure(string msg);
        bad_words++;
        if (bad_words <= 10) $display("%s", msg);
    endfunction

    function automatic void add_cfg(logic [CFG_AW-1:0] idx, logic [31:0] val);
        t_plan_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        plan_q.push_back(r);
    endfunction

    function automatic void add_typed(bit req, bit ax, logic [31:0] cmd, logic [31:0] pos,
                                      logic [31:0] vel, bit typed, logic [31:0] cur,
                                      bit spd, bit chit);
        t_plan_row r;
        r = '{default: '0};
        r.req = req;
        r.ax = ax;
        r.cmd = cmd;
        r.pos = pos;
        r.vel = vel;
        r.typed = typed;
        r.word = '{current: cur, speed_hit: spd, current_hit: chit};
        plan_q.push_back(r);
    endfunction

    function automatic void add_item(bit req, bit ax, logic [31:0] cmd, logic [31:0] pos,
                                     logic [31:0] vel);
        add_typed(req, ax, cmd, pos, vel, 1'b0, '0, 1'b0, 1'b0);
    endfunction

    function automatic int pick_gap(bit quiet);
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 9);
        if (roll < 5) return 0;
        if (roll < 9) return $urandom_range(1, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] near_word();
        return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    function automatic logic [31:0] rand_q16_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3, 4: return $urandom();
            default: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            4, 5: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return $urandom();
        endcase
    endfunction

    // top bit is random, the block keeps only 31
    function automatic logic [31:0] rand_limit();
        logic [30:0] lim;
        case ($urandom_range(0, 7))
            0: lim = '0;
            1: lim = '1;
            2, 3: lim = 31'($urandom());
            default: lim = 31'($urandom_range(0, 1 << 24));
        endcase
        return {1'($urandom_range(0, 1)), lim};
    endfunction

    task automatic settle_core();
        @(negedge i_clk) s_tvalid <= 1'b0;
        while (torque_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_COEF_A:        gains.coef_a = val;
            CFG_COEF_B:        gains.coef_b = val;
            CFG_COEF_C:        gains.coef_c = val;
            CFG_COEF_D:        gains.coef_d = val;
            CFG_POS_GAIN:      gains.pos_gain = val;
            CFG_SPEED_LIMIT:   gains.speed_limit = val[30:0];
            CFG_CURRENT_LIMIT: gains.current_limit = val[30:0];
            default: ;
        endcase
        @(negedge i_clk) i_cfg_wen <= 1'b0;
    endtask

    task automatic send_item(input bit req, input bit ax, input logic [31:0] cmd,
                             input logic [31:0] pos, input logic [31:0] vel,
                             input bit typed, input t_torque_cmd typed_word, input int gap);
        t_torque_cmd predicted;
        if (gap > 0) begin
            @(negedge i_clk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata <= {vel, pos, cmd};
        s_tuser <= {ax, req};
        do @(posedge i_clk); while (!s_tready);
        predicted = predict_current(req, ax, cmd, pos, vel);
        torque_q.push_back(typed ? typed_word : predicted);
    endtask

    // receiver stalls: long ready stretches, mostly short stalls, a few long ones
    initial begin : ready_gen
        int n;
        bit on;
        forever begin
            on = ($urandom_range(0, 9) < 6);
            if (on) n = $urandom_range(1, 40);
            else if ($urandom_range(0, 7) == 0) n = $urandom_range(15, 60);
            else n = $urandom_range(1, 3);
            @(negedge i_clk) m_tready <= on;
            repeat (n - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_word
        t_torque_cmd want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (torque_q.size() == 0) begin
                note_failure($sformatf("unexpected result word: current %h flags %b",
                                       m_tdata, m_tuser));
            end else begin
                want = torque_q.pop_front();
                if (m_tdata !== want.current || m_tuser[0] !== want.speed_hit
                        || m_tuser[1] !== want.current_hit) begin
                    note_failure($sformatf({"mismatch: current exp %h got %h, speed flag ",
                                            "exp %b got %b, current flag exp %b got %b"},
                                           want.current, m_tdata, want.speed_hit,
                                           m_tuser[0], want.current_hit, m_tuser[1]));
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        bit req;
        bit ax;
        logic [31:0] cmd;
        logic [31:0] pos;
        logic [31:0] vel;

        gains.coef_a = 32'sd65536;
        gains.coef_b = '0;
        gains.coef_c = '0;
        gains.coef_d = '0;
        gains.pos_gain = '0;
        gains.speed_limit = '1;
        gains.current_limit = '1;
        axis_x[0] = '0;
        axis_x[1] = '0;

        // defaults: no current path, only the speed clamp can fire
        add_typed(1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0,
                  1'b0, 1'b0);
        add_typed(1'b0, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 32'h0,
                  1'b1, 1'b0);
        add_typed(1'b1, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0,
                  1'b0, 1'b0);
        add_typed(1'b0, 1'b1, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0,
                  1'b0, 1'b0);
        // unity feedthrough, current limit 100.0, unused index ignored
        add_cfg(CFG_COEF_D, 32'h0001_0000);
        add_cfg(CFG_CURRENT_LIMIT, 32'h0064_0000);
        add_cfg(CFG_UNUSED, 32'h1234_5678);
        add_typed(1'b0, 1'b0, 32'h0005_0000, 32'h0, 32'h0000_0000, 1'b1, 32'h0005_0000,
                  1'b0, 1'b0);
        add_typed(1'b0, 1'b1, 32'h0064_0000, 32'h0, 32'h0000_0000, 1'b1, 32'h0064_0000,
                  1'b0, 1'b0);
        add_typed(1'b0, 1'b0, 32'h0064_0001, 32'h0, 32'h0000_0000, 1'b1, 32'h0064_0000,
                  1'b0, 1'b1);
        add_typed(1'b0, 1'b1, 32'hff38_0000, 32'h0, 32'h0000_0000, 1'b1, 32'hff9c_0000,
                  1'b0, 1'b1);
        // velocity error needs 33 bits
        add_typed(1'b0, 1'b0, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 1'b1, 32'h0064_0000,
                  1'b0, 1'b1);
        add_typed(1'b0, 1'b1, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 1'b1, 32'hff9c_0000,
                  1'b1, 1'b1);
        // floor rounding of negative products
        add_cfg(CFG_COEF_D, 32'hffff_ffff);
        add_cfg(CFG_CURRENT_LIMIT, 32'h7fff_ffff);
        add_typed(1'b0, 1'b0, 32'h0000_0001, 32'h0, 32'h0000_0000, 1'b1, 32'hffff_ffff,
                  1'b0, 1'b0);
        add_typed(1'b0, 1'b1, 32'hffff_ffff, 32'h0, 32'h0000_0000, 1'b1, 32'h0000_0000,
                  1'b0, 1'b0);
        // position error saturation and state saturation
        add_cfg(CFG_POS_GAIN, 32'h7fff_ffff);
        add_cfg(CFG_SPEED_LIMIT, 32'h03e8_0000);
        add_cfg(CFG_COEF_B, 32'h7fff_ffff);
        add_cfg(CFG_COEF_A, 32'h8000_0000);
        add_cfg(CFG_COEF_C, 32'h0001_0000);
        add_item(1'b1, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        add_item(1'b1, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        add_item(1'b0, 1'b0, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
        add_item(1'b0, 1'b1, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
        add_item(1'b0, 1'b0, 32'h0000_1234, 32'h0, 32'hffff_0000);
        // zero limits
        add_cfg(CFG_SPEED_LIMIT, 32'h8000_0000);
        add_cfg(CFG_CURRENT_LIMIT, 32'h0000_0000);
        add_item(1'b0, 1'b1, 32'h0000_0001, 32'h0, 32'h0000_0000);
        add_item(1'b1, 1'b0, 32'h0010_0000, 32'hfff0_0000, 32'h0001_0000);
        // most negative gain
        add_cfg(CFG_SPEED_LIMIT, 32'h7fff_ffff);
        add_cfg(CFG_CURRENT_LIMIT, 32'hffff_ffff);
        add_cfg(CFG_POS_GAIN, 32'h8000_0000);
        add_cfg(CFG_COEF_A, 32'h0000_8000);
        add_item(1'b1, 1'b1, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        add_item(1'b1, 1'b0, 32'hffff_fff0, 32'h0000_0010, 32'h1234_5678);
        add_item(1'b1, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'hedcb_a987);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_q[i]) begin
            if (plan_q[i].is_cfg) begin
                if (i == 0 || !plan_q[i-1].is_cfg) settle_core();
                write_reg(plan_q[i].idx, plan_q[i].val);
            end else begin
                send_item(plan_q[i].req, plan_q[i].ax, plan_q[i].cmd, plan_q[i].pos,
                          plan_q[i].vel, plan_q[i].typed, plan_q[i].word, pick_gap(1'b0));
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            settle_core();
            for (int r = 0; r <= int'(CFG_CURRENT_LIMIT); r++) begin
                write_reg(CFG_AW'(r), (r < int'(CFG_SPEED_LIMIT)) ? rand_coef() : rand_limit());
            end
            if (phase % 2 == 0) write_reg(CFG_UNUSED, $urandom());
            for (int k = 0; k < 75; k++) begin
                req = 1'($urandom_range(0, 1));
                ax = 1'($urandom_range(0, 1));
                cmd = rand_q16_word();
                pos = ($urandom_range(0, 3) == 0) ? rand_q16_word() : cmd - near_word();
                if ($urandom_range(0, 3) == 0) vel = rand_q16_word();
                else vel = req ? near_word() : cmd + near_word();
                send_item(req, ax, cmd, pos, vel, 1'b0, '0, pick_gap(phase % 3 == 1));
            end
        end

        settle_core();
        if (bad_words == 0 && torque_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/cpvp_pkg.sv
hdl/cpvp_useq.sv
hdl/cpvp_dp.sv
hdl/cascaded_position_velocity_pi_core.sv
verif/cascaded_position_velocity_pi_core_tb.sv
